@@ design/krd_pkg.sv @@
// shared types, constants and character map for the keypad release decoder
`timescale 1ns / 1ps
`default_nettype none

package krd_pkg;

	localparam int unsigned MATRIX_W = 56;
	localparam int unsigned ROWS_W   = 48;   // rows 1 to 6 of the matrix
	localparam int unsigned POS_W    = 6;

	// bit positions, 8*row+column
	localparam int unsigned BIT_SHIFT  = 5;
	localparam int unsigned BIT_SYMBOL = 15;
	localparam int unsigned BIT_LEFT   = 49;
	localparam int unsigned BIT_MODE   = 6;
	localparam int unsigned BIT_DOWN   = 48;
	localparam int unsigned BIT_RIGHT  = 50;
	localparam int unsigned BIT_UP     = 51;
	localparam int unsigned BIT_DELETE = 7;
	localparam int unsigned BIT_ENTER  = 40;

	// modifier modes
	localparam logic [1:0] MOD_NONE   = 2'd0;
	localparam logic [1:0] MOD_SHIFT  = 2'd1;
	localparam logic [1:0] MOD_SYMBOL = 2'd2;

	// special key codes
	localparam logic [2:0] SPC_NONE   = 3'd0;
	localparam logic [2:0] SPC_LEFT   = 3'd1;
	localparam logic [2:0] SPC_MODE   = 3'd2;
	localparam logic [2:0] SPC_DOWN   = 3'd3;
	localparam logic [2:0] SPC_RIGHT  = 3'd4;
	localparam logic [2:0] SPC_UP     = 3'd5;
	localparam logic [2:0] SPC_DELETE = 3'd6;
	localparam logic [2:0] SPC_ENTER  = 3'd7;

	localparam logic [7:0] CASE_OFFSET = 8'hE0;   // 'A' - 'a' modulo 256

	typedef struct packed {
		logic [7:0] key_char;
		logic [2:0] special_key;
		logic [1:0] modifier_now;
	} krd_result_t;

	// first letter of each column 1..6: "xsnida"
	function automatic logic [7:0] letter_base(input logic [2:0] col);
		logic [7:0] b;
		case (col)
			3'd1:    b = 8'h78;
			3'd2:    b = 8'h73;
			3'd3:    b = 8'h6E;
			3'd4:    b = 8'h69;
			3'd5:    b = 8'h64;
			3'd6:    b = 8'h61;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// first digit of each column 1..3: "147"
	function automatic logic [7:0] digit_base(input logic [2:0] col);
		logic [7:0] b;
		case (col)
			3'd1:    b = 8'h31;
			3'd2:    b = 8'h34;
			3'd3:    b = 8'h37;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// ascii of a key in rows 1..6, using the mode in force before the scan
	function automatic logic [7:0] map_char(input logic [1:0] mode, input logic [2:0] col,
			input logic [2:0] row);
		logic [7:0] ch;
		logic [7:0] offs;
		ch   = 8'h00;
		offs = (mode == MOD_SHIFT) ? CASE_OFFSET : 8'h00;
		if (mode == MOD_NONE || mode == MOD_SHIFT) begin
			if (col == 3'd0 && row == 3'd2) begin
				ch = 8'h20;
			end else if (col >= 3'd1 && col <= 3'd6 && (col != 3'd6 || row < 3'd4)) begin
				ch = letter_base(col) + {5'd0, row} - 8'd1 + offs;
			end
		end else begin
			if (col == 3'd4 && row == 3'd3) begin
				ch = 8'h28;
			end else if (col == 3'd4 && row == 3'd4) begin
				ch = 8'h29;
			end else if (col == 3'd0 && row == 3'd2) begin
				ch = 8'h30;
			end else if (col == 3'd4 && row == 3'd5) begin
				ch = 8'h2F;
			end else if (col == 3'd1 && row == 3'd5) begin
				ch = 8'h2B;
			end else if (col == 3'd2 && row == 3'd5) begin
				ch = 8'h2D;
			end else if (col == 3'd3 && row == 3'd5) begin
				ch = 8'h2A;
			end else if (row >= 3'd2 && row <= 3'd4 && col >= 3'd1 && col <= 3'd3) begin
				ch = digit_base(col) + {5'd0, row} - 8'd2;
			end
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ design/keypad_release_decoder_core.sv @@
// top level of the keypad release decoder: scan register, decode, result register
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake             payload
// scan     in         in_valid / in_stall   key_matrix[55:0]
// result   out        out_valid / out_stall key_char[7:0], special_key[2:0], modifier_now[1:0]
//
// one scan beat per cycle sustained while out_stall is low; the edge that takes a beat
// loads the scan register; its decode enters the result register when that one is free
// the previous scan and the modifier mode update as a beat moves into the result register
// reset clears both valid flags, the previous scan and the mode
// out_stall holds the result register; in_stall rises only when the scan register
// is full and cannot move on

module keypad_release_decoder_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [krd_pkg::MATRIX_W-1:0] key_matrix,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [7:0]                        key_char,
	output logic [2:0]                        special_key,
	output logic [1:0]                        modifier_now
);

	// scan register
	logic                         valid_s1;
	logic [krd_pkg::MATRIX_W-1:0] matrix_s1;

	// decoder state
	logic [krd_pkg::MATRIX_W-1:0] prev_q;
	logic [1:0]                   mode_q;

	// result register
	logic                 valid_s2;
	krd_pkg::krd_result_t result_s2;

	krd_pkg::krd_result_t result;
	logic                 out_free;
	logic                 advance;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	krd_decode u_decode (
		.cur_matrix  (matrix_s1),
		.prev_matrix (prev_q),
		.mode        (mode_q),
		.result      (result)
	);

	// scan register: load whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			matrix_s1 <= key_matrix;
		end
	end

	// previous scan and mode follow the beat that enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			mode_q <= krd_pkg::MOD_NONE;
		end else if (advance) begin
			prev_q <= matrix_s1;
			mode_q <= result.modifier_now;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign key_char     = result_s2.key_char;
	assign special_key  = result_s2.special_key;
	assign modifier_now = result_s2.modifier_now;

	// mode never reaches the unused code
	assert property (@(posedge clk) disable iff (!arst_n) mode_q != 2'd3)
		else $error("modifier mode reached unused code");

	// a special key always clears the mode and carries no character
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && special_key != krd_pkg::SPC_NONE) |->
		(key_char == 8'h00 && modifier_now == krd_pkg::MOD_NONE))
		else $error("special key beat with character or mode");

	// the scan that moves on becomes the previous scan
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> prev_q == $past(matrix_s1))
		else $error("previous scan not updated");

	// mode register tracks the reported mode
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_s2 && mode_q == modifier_now))
		else $error("mode register out of step with result");

endmodule

`default_nettype wire

@@ design/krd_decode.sv @@
// release detection, priority selection and character mapping for one scan
`timescale 1ns / 1ps
`default_nettype none

module krd_decode (
	input  wire logic [krd_pkg::MATRIX_W-1:0] cur_matrix,
	input  wire logic [krd_pkg::MATRIX_W-1:0] prev_matrix,
	input  wire logic [1:0]                   mode,
	output krd_pkg::krd_result_t              result
);

	logic [krd_pkg::MATRIX_W-1:0] rel;
	logic [krd_pkg::ROWS_W-1:0]   rows;
	logic [krd_pkg::POS_W-1:0]    pos;
	logic [2:0]                   row;

	assign rel  = prev_matrix & ~cur_matrix;
	assign rows = rel[krd_pkg::MATRIX_W-1:8];

	// lowest set bit of rows 1..6
	always_comb begin
		pos = '0;
		for (int i = krd_pkg::ROWS_W - 1; i >= 0; i--) begin
			if (rows[i]) begin
				pos = krd_pkg::POS_W'(i);
			end
		end
	end

	assign row = pos[5:3] + 3'd1;

	always_comb begin
		result.key_char     = 8'h00;
		result.special_key  = krd_pkg::SPC_NONE;
		result.modifier_now = krd_pkg::MOD_NONE;
		if (rel[krd_pkg::BIT_SHIFT]) begin
			result.modifier_now = mode[0] ? krd_pkg::MOD_NONE : krd_pkg::MOD_SHIFT;
		end else if (rel[krd_pkg::BIT_SYMBOL]) begin
			result.modifier_now = mode[1] ? krd_pkg::MOD_NONE : krd_pkg::MOD_SYMBOL;
		end else if (rel[krd_pkg::BIT_LEFT]) begin
			result.special_key = krd_pkg::SPC_LEFT;
		end else if (rel[krd_pkg::BIT_MODE]) begin
			result.special_key = krd_pkg::SPC_MODE;
		end else if (rel[krd_pkg::BIT_DOWN]) begin
			result.special_key = krd_pkg::SPC_DOWN;
		end else if (rel[krd_pkg::BIT_RIGHT]) begin
			result.special_key = krd_pkg::SPC_RIGHT;
		end else if (rel[krd_pkg::BIT_UP]) begin
			result.special_key = krd_pkg::SPC_UP;
		end else if (rel[krd_pkg::BIT_DELETE]) begin
			result.special_key = krd_pkg::SPC_DELETE;
		end else if (rel[krd_pkg::BIT_ENTER]) begin
			result.special_key = krd_pkg::SPC_ENTER;
		end else if (|rows) begin
			result.key_char = krd_pkg::map_char(mode, pos[2:0], row);
		end else begin
			result.modifier_now = mode;   // nothing released, mode holds
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/krd_tb_pkg.sv @@
// scoreboard class for the keypad release decoder testbench
`timescale 1ns / 1ps

package krd_tb_pkg;

	// first character of each column, column 1 in the top byte
	localparam logic [47:0] LETTER_COLS = "xsnida";
	localparam logic [23:0] DIGIT_COLS  = "147";
	localparam int          MAX_PRINTED = 40;

	class krd_scoreboard;

		logic [krd_pkg::MATRIX_W-1:0] last_scan;
		logic [1:0]                   mode;
		krd_pkg::krd_result_t         expected_q[$];
		int                           errors;

		function new();
			last_scan = '0;
			mode      = krd_pkg::MOD_NONE;
			errors    = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// ascii of a key in rows 1..6 under the mode held before the scan
		function logic [7:0] key_ascii(logic [1:0] mode_before, int unsigned col,
				int unsigned row);
			logic [7:0] ch;
			if (mode_before == krd_pkg::MOD_NONE || mode_before == krd_pkg::MOD_SHIFT) begin
				if (col == 0 && row == 2) begin
					return 8'h20;
				end
				if (col < 1 || col > 6 || (col == 6 && row >= 4)) begin
					return 8'h00;
				end
				ch = LETTER_COLS[8 * (6 - col) +: 8] + 8'(row) - 8'd1;
				if (mode_before == krd_pkg::MOD_SHIFT) begin
					ch = ch + krd_pkg::CASE_OFFSET;
				end
				return ch;
			end
			// symbol mode, also taken for the unreachable mode 3
			if (col == 4 && row == 3) return "(";
			if (col == 4 && row == 4) return ")";
			if (col == 0 && row == 2) return "0";
			if (col == 4 && row == 5) return "/";
			if (col == 1 && row == 5) return "+";
			if (col == 2 && row == 5) return "-";
			if (col == 3 && row == 5) return "*";
			if (row >= 2 && row <= 4 && col >= 1 && col <= 3) begin
				return DIGIT_COLS[8 * (3 - col) +: 8] + 8'(row) - 8'd2;
			end
			return 8'h00;
		endfunction

		// release detection and priority decode of one scan
		function krd_pkg::krd_result_t decode_release(logic [krd_pkg::MATRIX_W-1:0] scan);
			logic [krd_pkg::MATRIX_W-1:0] rel;
			logic [krd_pkg::ROWS_W-1:0]   rows;
			logic [1:0]                   mode_prev;
			krd_pkg::krd_result_t         r;
			int unsigned                  pos;
			rel           = last_scan & ~scan;
			mode_prev     = mode;
			last_scan     = scan;
			r.key_char    = 8'h00;
			r.special_key = krd_pkg::SPC_NONE;
			rows          = rel[krd_pkg::MATRIX_W-1:8];
			if (rel[krd_pkg::BIT_SHIFT]) begin
				mode = mode_prev[0] ? krd_pkg::MOD_NONE : krd_pkg::MOD_SHIFT;
			end else if (rel[krd_pkg::BIT_SYMBOL]) begin
				mode = mode_prev[1] ? krd_pkg::MOD_NONE : krd_pkg::MOD_SYMBOL;
			end else if (rel[krd_pkg::BIT_LEFT]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_LEFT;
			end else if (rel[krd_pkg::BIT_MODE]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_MODE;
			end else if (rel[krd_pkg::BIT_DOWN]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_DOWN;
			end else if (rel[krd_pkg::BIT_RIGHT]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_RIGHT;
			end else if (rel[krd_pkg::BIT_UP]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_UP;
			end else if (rel[krd_pkg::BIT_DELETE]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_DELETE;
			end else if (rel[krd_pkg::BIT_ENTER]) begin
				mode = krd_pkg::MOD_NONE;
				r.special_key = krd_pkg::SPC_ENTER;
			end else if (rows != '0) begin
				pos = 0;
				while (!rows[pos]) begin
					pos++;
				end
				mode = krd_pkg::MOD_NONE;
				r.key_char = key_ascii(mode_prev, pos % 8, pos / 8 + 1);
			end
			r.modifier_now = mode;
			return r;
		endfunction

		function void note_scan(logic [krd_pkg::MATRIX_W-1:0] scan);
			expected_q.push_back(decode_release(scan));
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTED) begin
				$display("%0t ns: mismatch: %s", $time, msg);
			end
			errors++;
		endtask

		task check_result(logic [7:0] key_char, logic [2:0] special_key,
				logic [1:0] modifier_now);
			krd_pkg::krd_result_t exp_r;
			if (expected_q.size() == 0) begin
				report("result beat with no scan outstanding");
				return;
			end
			exp_r = expected_q.pop_front();
			if (key_char !== exp_r.key_char) begin
				report($sformatf("key_char got %02h expected %02h", key_char, exp_r.key_char));
			end
			if (special_key !== exp_r.special_key) begin
				report($sformatf("special_key got %0d expected %0d", special_key,
					exp_r.special_key));
			end
			if (modifier_now !== exp_r.modifier_now) begin
				report($sformatf("modifier_now got %0d expected %0d", modifier_now,
					exp_r.modifier_now));
			end
		endtask

	endclass

endpackage

@@ tb/sv/keypad_release_decoder_core_tb.sv @@
// testbench top for the keypad release decoder core
`timescale 1ns / 1ps

module keypad_release_decoder_core_tb;

	localparam int RANDOM_SCANS    = 800;
	localparam int HOLD_OFF_CYCLES = 90;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 10;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic [krd_pkg::MATRIX_W-1:0] key_matrix   = '0;
	logic                         out_stall    = 1'b0;
	logic                         in_stall;
	logic                         out_valid;
	logic [7:0]                   key_char;
	logic [2:0]                   special_key;
	logic [1:0]                   modifier_now;

	krd_tb_pkg::krd_scoreboard sb = new();

	// sender pacing
	int burst_left    = 0;
	bit no_gaps       = 1'b0;
	// asks the receiver for one long hold-off
	bit hold_off_req  = 1'b0;
	int cycle_count   = 0;

	keypad_release_decoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_matrix   (key_matrix),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_char     (key_char),
		.special_key  (special_key),
		.modifier_now (modifier_now)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [krd_pkg::MATRIX_W-1:0] key_bit(int unsigned pos);
		return {{(krd_pkg::MATRIX_W-1){1'b0}}, 1'b1} << pos;
	endfunction

	function automatic logic [krd_pkg::MATRIX_W-1:0] random_matrix();
		logic [63:0] rnd;
		rnd = {$urandom(), $urandom()};
		return rnd[krd_pkg::MATRIX_W-1:0];
	endfunction

	// modifier and special keys, picked more often than plain keys
	function automatic int unsigned hot_key(int unsigned idx);
		case (idx)
			0:       return krd_pkg::BIT_SHIFT;
			1:       return krd_pkg::BIT_SYMBOL;
			2:       return krd_pkg::BIT_LEFT;
			3:       return krd_pkg::BIT_MODE;
			4:       return krd_pkg::BIT_DOWN;
			5:       return krd_pkg::BIT_RIGHT;
			6:       return krd_pkg::BIT_UP;
			7:       return krd_pkg::BIT_DELETE;
			default: return krd_pkg::BIT_ENTER;
		endcase
	endfunction

	// next scan from the keys held now: mostly single presses and releases,
	// with some bulk releases, multi-key changes and noise
	function automatic logic [krd_pkg::MATRIX_W-1:0] evolve_scan(
			logic [krd_pkg::MATRIX_W-1:0] held);
		int unsigned pick;
		int unsigned start;
		int unsigned idx;
		int          r;
		r = $urandom_range(0, 99);
		if (r >= 40 && r < 78 && held == '0) begin
			r = 0;
		end
		if (r < 40) begin
			// press one more key
			pick = ($urandom_range(0, 4) == 0) ? hot_key($urandom_range(0, 8))
				: $urandom_range(0, krd_pkg::MATRIX_W - 1);
			return held | key_bit(pick);
		end else if (r < 78) begin
			// let go of one held key, searched from a random start
			start = $urandom_range(0, krd_pkg::MATRIX_W - 1);
			for (int i = 0; i < krd_pkg::MATRIX_W; i++) begin
				idx = (start + i) % krd_pkg::MATRIX_W;
				if (held[idx]) begin
					return held & ~key_bit(idx);
				end
			end
			return held;
		end else if (r < 84) begin
			return '0;
		end else if (r < 90) begin
			return held ^ (random_matrix() & random_matrix());
		end else if (r < 95) begin
			return random_matrix();
		end
		return held;
	endfunction

	// offers one scan beat and waits for it to be taken; called at a falling edge
	// and returns at one
	task automatic send_scan(input logic [krd_pkg::MATRIX_W-1:0] scan);
		int gap;
		if (burst_left == 0 && !no_gaps) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid   <= 1'b1;
		key_matrix <= scan;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_scan(scan);
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
	endtask

	// sender pauses until every expected result beat has come back
	task automatic drain_results();
		in_valid   <= 1'b0;
		burst_left = 0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
		@(negedge clk);
	endtask

	// result side: sample at the rising edge, check every beat taken
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(key_char, special_key, modifier_now);
		end
	end

	// receiver stall pattern: phases of random length, each with its own stall
	// density, plus one long hold-off on request
	initial begin : receiver
		int phase_left;
		int stall_pct;
		phase_left = 0;
		stall_pct  = 0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (phase_left == 0) begin
					case ($urandom_range(0, 3))
						0:       stall_pct = 0;
						1:       stall_pct = 20;
						2:       stall_pct = 50;
						default: stall_pct = 85;
					endcase
					phase_left = $urandom_range(10, 60);
				end
				phase_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				@(negedge clk);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [krd_pkg::MATRIX_W-1:0] held;
		logic [krd_pkg::MATRIX_W-1:0] specials;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every key pressed and released at once: shift wins and toggles on,
		// then a second round toggles it off
		send_scan('0);
		send_scan('1);
		send_scan('0);
		send_scan('1);
		send_scan('0);

		// symbol toggle then a digit key in symbol mode
		send_scan(key_bit(krd_pkg::BIT_SYMBOL));
		send_scan('0);
		send_scan(key_bit(17));
		send_scan('0);

		// all special keys held, let go from lowest priority up so each one reports
		specials = key_bit(krd_pkg::BIT_LEFT) | key_bit(krd_pkg::BIT_MODE) |
			key_bit(krd_pkg::BIT_DOWN) | key_bit(krd_pkg::BIT_RIGHT) |
			key_bit(krd_pkg::BIT_UP) | key_bit(krd_pkg::BIT_DELETE) |
			key_bit(krd_pkg::BIT_ENTER);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_ENTER);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_DELETE);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_UP);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_RIGHT);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_DOWN);
		send_scan(specials);
		specials &= ~key_bit(krd_pkg::BIT_MODE);
		send_scan(specials);
		send_scan('0);

		// shift then a letter gives upper case
		send_scan(key_bit(krd_pkg::BIT_SHIFT));
		send_scan('0);
		send_scan(key_bit(9));
		send_scan('0);

		// plain row 0 key is ignored, unmapped top corner still clears the mode
		send_scan(key_bit(0) | key_bit(krd_pkg::MATRIX_W - 1));
		send_scan(key_bit(krd_pkg::MATRIX_W - 1));
		send_scan('0);

		drain_results();

		held = '0;
		for (int n = 0; n < RANDOM_SCANS; n++) begin
			if (n == 300) begin
				// long receiver hold-off with the sender offering back to back
				hold_off_req = 1'b1;
				no_gaps      = 1'b1;
			end else if (n == 420) begin
				no_gaps = 1'b0;
			end
			if (n % 200 == 199) begin
				drain_results();
			end
			held = evolve_scan(held);
			send_scan(held);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
